// ----- hdl/pfa_pkg.sv -----
// Shared constants, codes and types for the page frame allocator.
package pfa_pkg;

  // Region geometry. PAGE_BYTES must be a power of two.
  localparam int unsigned NUM_PAGES  = 2048;
  localparam int unsigned PAGE_BYTES = 4096;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned USED_W     = 12;
  localparam int unsigned STATUS_W   = 3;

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned CNT_W      = $clog2(NUM_PAGES + 1);

  // Free map is held as rows of ROW_W bits, one bit per page, 1 = free.
  localparam int unsigned ROW_W      = 32;
  localparam int unsigned BIT_W      = $clog2(ROW_W);
  localparam int unsigned NUM_ROWS   = (NUM_PAGES + ROW_W - 1) / ROW_W;
  localparam int unsigned ROWA_W     = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int unsigned PG_W       = ROWA_W + BIT_W;

  // Command codes.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL         = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_REGION   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd4;

  // Free map read address select.
  typedef enum logic [1:0] {
    RD_FIRST,
    RD_PAGE,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] release_addr;
  } pfa_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_addr;
    logic [STATUS_W-1:0] status;
    logic                is_full;
    logic [USED_W-1:0]   pages_used;
  } pfa_rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic                capture;
    logic                scan_clr;
    logic                scan_inc;
    logic                alloc_commit;
    logic                rel_commit;
    rd_sel_e             rd_sel;
    logic                res_load;
    logic                res_addr_en;
    logic [STATUS_W-1:0] res_status;
  } pfa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_release;
    logic full;
    logic empty;
    logic in_region;
    logic row_has_free;
    logic page_free;
    logic last_row;
  } pfa_sts_t;

endpackage

// ----- hdl/pfa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module pfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pfa_ctrl.sv -----
// Sequencing state machine for the page frame allocator.
module pfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pfa_pkg::pfa_sts_t sts_i,
  output pfa_pkg::pfa_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_REL   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel     = pfa_pkg::RD_NEXT;
    cmd_o.res_status = pfa_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.is_release) begin
          if (sts_i.full) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = pfa_pkg::ST_FULL;
            state_d          = S_IDLE;
          end else begin
            cmd_o.scan_clr = 1'b1;
            cmd_o.rd_sel   = pfa_pkg::RD_FIRST;
            state_d        = S_SCAN;
          end
        end else if (sts_i.empty) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = pfa_pkg::ST_EMPTY;
          state_d          = S_IDLE;
        end else if (!sts_i.in_region) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = pfa_pkg::ST_NOT_REGION;
          state_d          = S_IDLE;
        end else begin
          cmd_o.rd_sel = pfa_pkg::RD_PAGE;
          state_d      = S_REL;
        end
      end
      S_SCAN: begin
        if (sts_i.row_has_free) begin
          cmd_o.alloc_commit = 1'b1;
          cmd_o.res_load     = 1'b1;
          cmd_o.res_addr_en  = 1'b1;
          cmd_o.res_status   = pfa_pkg::ST_OK;
          state_d            = S_IDLE;
        end else if (sts_i.last_row) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = pfa_pkg::ST_FULL;
          state_d          = S_IDLE;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_REL: begin
        cmd_o.res_load = 1'b1;
        state_d        = S_IDLE;
        if (sts_i.page_free) begin
          cmd_o.res_status = pfa_pkg::ST_ALREADY_FREE;
        end else begin
          cmd_o.rel_commit = 1'b1;
          cmd_o.res_status = pfa_pkg::ST_OK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ----- hdl/pfa_dpath.sv -----
// Datapath: free map, used count, region base, address math and result word.
module pfa_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfa_pkg::ADDR_W-1:0]    cfg_wdata_i,
  input  pfa_pkg::pfa_req_t             req_i,
  input  pfa_pkg::pfa_cmd_t             cmd_i,
  output pfa_pkg::pfa_sts_t             sts_o,
  output pfa_pkg::pfa_rsp_t             rsp_o,
  output logic                          rsp_valid_o
);

  localparam int unsigned AW = pfa_pkg::ADDR_W;
  localparam int unsigned RW = pfa_pkg::ROW_W;
  localparam int unsigned RA = pfa_pkg::ROWA_W;
  localparam int unsigned BW = pfa_pkg::BIT_W;
  localparam int unsigned PW = pfa_pkg::PG_W;
  localparam int unsigned CW = pfa_pkg::CNT_W;

  // One bit wider than a page index so the page count itself fits.
  localparam logic [PW:0] PG_LIMIT = (PW+1)'(pfa_pkg::NUM_PAGES);

  logic                   cmd_q;
  logic [AW-1:0]          raddr_q;
  logic [AW-1:0]          base_q;
  logic [CW-1:0]          count_q, count_d;
  logic [RA-1:0]          ptr_q, ptr_d;
  logic [RA-1:0]          rd_row_q;
  logic [pfa_pkg::NUM_ROWS-1:0] row_valid_q;
  pfa_pkg::pfa_rsp_t      rsp_q;
  logic                   rsp_valid_q;

  logic [AW-1:0]          offset;
  logic                   in_region;
  logic [PW-1:0]          rel_pg;
  logic [RA-1:0]          rel_row;
  logic [BW-1:0]          rel_bit;

  logic [RA-1:0]          ram_raddr;
  logic [RA-1:0]          ram_waddr;
  logic [RW-1:0]          ram_wdata;
  logic                   ram_we;
  logic [RW-1:0]          ram_rdata;

  logic [RW-1:0]          row_mask;
  logic [RW-1:0]          row_free;
  logic [RW-1:0]          low_free;
  logic [BW-1:0]          free_bit;
  logic [AW-1:0]          alloc_addr;

  // Release address decode.
  assign offset    = raddr_q - base_q;
  assign in_region = (offset[pfa_pkg::PAGE_SHIFT-1:0] == '0) &&
                     ((offset >> pfa_pkg::PAGE_SHIFT) < AW'(pfa_pkg::NUM_PAGES));
  assign rel_pg    = PW'(offset >> pfa_pkg::PAGE_SHIFT);
  assign rel_row   = rel_pg[PW-1:BW];
  assign rel_bit   = rel_pg[BW-1:0];

  // Read data view: unwritten rows read as all free, pages past the end never free.
  always_comb begin
    for (int b = 0; b < RW; b++) begin
      row_mask[b] = ({1'b0, rd_row_q, BW'(b)} < PG_LIMIT);
    end
  end

  assign row_free = (row_valid_q[rd_row_q] ? ram_rdata : '1) & row_mask;
  assign low_free = row_free & (~row_free + RW'(1));

  always_comb begin
    free_bit = '0;
    for (int b = 0; b < RW; b++) begin
      if (low_free[b]) begin
        free_bit = free_bit | BW'(b);
      end
    end
  end

  assign alloc_addr = base_q + (AW'({ptr_q, free_bit}) << pfa_pkg::PAGE_SHIFT);

  // Free map port control.
  always_comb begin
    case (cmd_i.rd_sel)
      pfa_pkg::RD_FIRST: ram_raddr = '0;
      pfa_pkg::RD_PAGE:  ram_raddr = rel_row;
      pfa_pkg::RD_NEXT:  ram_raddr = ptr_q + RA'(1);
      default:           ram_raddr = ptr_q;
    endcase
  end

  assign ram_we    = cmd_i.alloc_commit | cmd_i.rel_commit;
  assign ram_waddr = cmd_i.alloc_commit ? ptr_q : rel_row;
  assign ram_wdata = cmd_i.alloc_commit ? (row_free & ~low_free)
                                        : (row_free | (RW'(1) << rel_bit));

  pfa_ram #(
    .WIDTH (RW),
    .DEPTH (pfa_pkg::NUM_ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.alloc_commit) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.rel_commit) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.scan_clr) begin
      ptr_d = '0;
    end else if (cmd_i.scan_inc) begin
      ptr_d = ptr_q + RA'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      count_q     <= '0;
      row_valid_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (ram_we) begin
        row_valid_q[ram_waddr] <= 1'b1;
      end
      rsp_valid_q <= cmd_i.res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= req_i.cmd;
      raddr_q <= req_i.release_addr;
    end
    ptr_q    <= ptr_d;
    rd_row_q <= ram_raddr;
    if (cmd_i.res_load) begin
      rsp_q.page_addr  <= cmd_i.res_addr_en ? alloc_addr : '0;
      rsp_q.status     <= cmd_i.res_status;
      rsp_q.is_full    <= (count_d >= CW'(pfa_pkg::NUM_PAGES));
      rsp_q.pages_used <= pfa_pkg::USED_W'(count_d);
    end
  end

  assign sts_o.is_release   = (cmd_q == pfa_pkg::CMD_RELEASE);
  assign sts_o.full         = (count_q >= CW'(pfa_pkg::NUM_PAGES));
  assign sts_o.empty        = (count_q == '0);
  assign sts_o.in_region    = in_region;
  assign sts_o.row_has_free = (row_free != '0);
  assign sts_o.page_free    = row_free[rel_bit];
  assign sts_o.last_row     = (ptr_q == RA'(pfa_pkg::NUM_ROWS - 1));

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

// ----- hdl/page_frame_allocator.sv -----
// Top level of the page frame allocator: controller plus datapath.
//
//  Channel   Ports                       Direction  Word
//  -------   -------------------------   ---------  ----------------------------------
//  request   start, busy, req_i          in         cmd, release_addr
//  result    rsp_valid_o, rsp_o          out        page_addr, status, is_full, pages_used
//  config    cfg_we_i, cfg_wdata_i       in         region_base
//
// A request word is taken on a clock edge with start high and busy low. Its result
// word is registered from the check state for an allocate into a full region or a
// release refused as nothing used or outside the region, after a read of the page's
// free map row for a release checked against the free map, and for any other allocate
// after the 32-page rows of the free map RAM are read in turn until a free page turns
// up (1 to NUM_PAGES/32 = 64 rows). busy drops as the result word comes out, so the next
// word can be taken on the edge that ends the result cycle. The result word shows on
// rsp_o for one cycle with rsp_valid_o; the receiver cannot stall it. Reset is
// asynchronous, active low; the free map starts all free through per-row valid
// flags, so there is no clearing pass after reset.
module page_frame_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  pfa_pkg::pfa_req_t          req_i,
  input  logic                       cfg_we_i,
  input  logic [pfa_pkg::ADDR_W-1:0] cfg_wdata_i,
  output pfa_pkg::pfa_rsp_t          rsp_o,
  output logic                       rsp_valid_o
);

  // Controller drives the datapath through one command struct and reads
  // back one status struct; nothing else crosses between them.
  pfa_pkg::pfa_cmd_t ctl_cmd;
  pfa_pkg::pfa_sts_t dp_sts;

  pfa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (dp_sts),
    .cmd_o  (ctl_cmd)
  );

  // Datapath holds region base, used count, the free map RAM and the
  // registered result word.
  pfa_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (ctl_cmd),
    .sts_o       (dp_sts),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

endmodule

// ----- hdl/pfa_checker.sv -----
// Port-level checks for the page frame allocator, bound to the top level.
module pfa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input pfa_pkg::pfa_req_t          req_i,
  input logic                       cfg_we_i,
  input logic [pfa_pkg::ADDR_W-1:0] cfg_wdata_i,
  input pfa_pkg::pfa_rsp_t          rsp_o,
  input logic                       rsp_valid_o
);

  // An accepted word keeps the block busy and gives no result next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !rsp_valid_o))
    else $error("accepted word did not make the block busy");

  // The result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("result strobe held longer than one cycle");

  // Failed results carry a zero address.
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status != pfa_pkg::ST_OK)) |-> (rsp_o.page_addr == '0))
    else $error("nonzero address on a failed request");

  // Full flag agrees with the used count, and a full status implies full.
  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> ((rsp_o.is_full ==
                      (rsp_o.pages_used == pfa_pkg::USED_W'(pfa_pkg::NUM_PAGES))) &&
                     ((rsp_o.status != pfa_pkg::ST_FULL) || rsp_o.is_full)))
    else $error("full flag inconsistent with used count or status");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (.*);
